### hdl/sdtfd_pkg.sv
// ----------------------------------------------------------------------------
// sdtfd_pkg
// Shared widths, types and helpers for the stereo dual-tap feedback delay.
// ----------------------------------------------------------------------------
`default_nettype none

package sdtfd_pkg;

    // sample and storage dimensions
    localparam int SAMPLE_W  = 24;
    localparam int MAX_DELAY = 65536;
    localparam int ADDR_W    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int LEN_W     = 17;
    localparam int COEF_W    = 16;
    localparam int NUM_TAPS  = 2;

    // datapath widths of the multiply-accumulate lanes
    localparam int OP_A_W = 32;
    localparam int OP_B_W = COEF_W + 1;
    localparam int ACC_W  = 50;

    // rounding shifts: coefficient products and the doubled volume product
    localparam int SHIFT_COEF = 15;
    localparam int SHIFT_VOL  = 14;
    localparam int ONE_Q15    = 1 << SHIFT_COEF;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [OP_A_W-1:0]   op_a_t;
    typedef logic signed [OP_B_W-1:0]   op_b_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // half-unit offsets preloaded into the accumulator for round to nearest
    localparam acc_t RND_COEF = acc_t'(1) <<< (SHIFT_COEF - 1);
    localparam acc_t RND_VOL  = acc_t'(1) <<< (SHIFT_VOL - 1);

    localparam acc_t SAT_HI = (acc_t'(1) <<< (SAMPLE_W - 1)) - acc_t'(1);
    localparam acc_t SAT_LO = ~SAT_HI;

    // clamp a wide value to the signed sample range
    function automatic sample_t sat_sample(acc_t v);
        sample_t r;
        if (v > SAT_HI) begin
            r = sample_t'(SAT_HI);
        end else if (v < SAT_LO) begin
            r = sample_t'(SAT_LO);
        end else begin
            r = sample_t'(v);
        end
        return r;
    endfunction

    // last position of a tap: length zero acts as one, long lengths clamp
    function automatic logic [ADDR_W-1:0] last_index(logic [LEN_W-1:0] len);
        logic [31:0] l;
        l = 32'(len);
        if (l == 32'd0) begin
            l = 32'd1;
        end
        if (l > 32'(MAX_DELAY)) begin
            l = 32'(MAX_DELAY);
        end
        return ADDR_W'(l - 32'd1);
    endfunction

    // unsigned q1.15 coefficient as a signed multiplier operand
    function automatic op_b_t coef_q15(logic [COEF_W-1:0] c);
        return op_b_t'({1'b0, c});
    endfunction

    // one minus a q1.15 coefficient, negative when the coefficient exceeds one
    function automatic op_b_t compl_q15(logic [COEF_W-1:0] c);
        return op_b_t'(ONE_Q15) - op_b_t'({1'b0, c});
    endfunction

endpackage

`default_nettype wire

### hdl/sdtfd_if.sv
// ----------------------------------------------------------------------------
// sdtfd_if
// Valid/ready stream interfaces for the input and output sample pairs.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdtfd_in_if
    import sdtfd_pkg::*;
    ();
    logic    valid;
    logic    ready;
    sample_t left_in;
    sample_t right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface sdtfd_out_if
    import sdtfd_pkg::*;
    ();
    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

### hdl/stereo_dual_tap_feedback_delay.sv
// ----------------------------------------------------------------------------
// stereo_dual_tap_feedback_delay
// Each sample pair runs through the fixed 16-step schedule of two shared
// multiply-accumulate lanes (one per tap); a new pair is accepted only while
// idle or as the previous one retires. A stalled output holds the last step
// until it frees.
// Reset: registers take their defaults; stores need no clearing pass, a
// per-tap wrap flag makes unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_dual_tap_feedback_delay
    import sdtfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    sdtfd_in_if.sink         sample_in,
    sdtfd_out_if.source      sample_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // register map
    localparam logic [2:0] REG_TAP1_LENGTH = 3'd0;
    localparam logic [2:0] REG_TAP2_LENGTH = 3'd1;
    localparam logic [2:0] REG_TAP_GAINS   = 3'd2;
    localparam logic [2:0] REG_TAP_PANS    = 3'd3;
    localparam logic [2:0] REG_FEEDBACKS   = 3'd4;
    localparam logic [2:0] REG_DAMPING     = 3'd5;
    localparam logic [2:0] REG_VOLUME      = 3'd6;
    localparam logic [2:0] REG_CROSSMIX    = 3'd7;

    // schedule steps, the same in both lanes
    localparam logic [3:0] STEP_XG_L   = 4'd0;
    localparam logic [3:0] STEP_PAN_L  = 4'd1;
    localparam logic [3:0] STEP_XG_R   = 4'd2;
    localparam logic [3:0] STEP_PAN_R  = 4'd3;
    localparam logic [3:0] STEP_MIX_L0 = 4'd4;
    localparam logic [3:0] STEP_MIX_L1 = 4'd5;
    localparam logic [3:0] STEP_MIX_R0 = 4'd6;
    localparam logic [3:0] STEP_MIX_R1 = 4'd7;
    localparam logic [3:0] STEP_FB_L   = 4'd8;
    localparam logic [3:0] STEP_FB_R   = 4'd9;
    localparam logic [3:0] STEP_DMP_L0 = 4'd10;
    localparam logic [3:0] STEP_DMP_L1 = 4'd11;
    localparam logic [3:0] STEP_DMP_R0 = 4'd12;
    localparam logic [3:0] STEP_DMP_R1 = 4'd13;
    localparam logic [3:0] STEP_VOL    = 4'd14;
    localparam logic [3:0] STEP_DONE   = 4'd15;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // configuration registers
    logic [LEN_W-1:0]  tap1_length_reg;
    logic [LEN_W-1:0]  tap2_length_reg;
    logic [31:0]       tap_gains_reg;
    logic [31:0]       tap_pans_reg;
    logic [31:0]       feedbacks_reg;
    logic [COEF_W-1:0] damping_reg;
    logic [COEF_W-1:0] volume_reg;
    logic [COEF_W-1:0] crossmix_reg;

    logic [2:0] cfg_idx;
    logic       cfg_we;
    logic       len_wr;

    // sequencer
    state_t     state_reg;
    state_t     state_next;
    logic [3:0] step_reg;
    logic [3:0] step_next;
    logic       run;
    logic       in_accept;
    logic       finish;

    // input sample pair and tap sums
    sample_t x_left_reg;
    sample_t x_right_reg;
    op_a_t   sum_left_reg;
    op_a_t   sum_right_reg;

    // output register
    logic    out_valid_reg;
    sample_t out_left_reg;
    sample_t out_right_reg;

    // per-tap state shared with the top-level logic
    acc_t             acc_reg     [NUM_TAPS];
    op_a_t            tl_reg      [NUM_TAPS];
    op_a_t            tr_reg      [NUM_TAPS];
    sample_t          hl_reg      [NUM_TAPS];
    sample_t          hr_reg      [NUM_TAPS];
    logic [ADDR_W-1:0] pos_reg    [NUM_TAPS];
    logic [ADDR_W-1:0] last_idx   [NUM_TAPS];
    logic             wrapped_reg [NUM_TAPS];

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite;
    assign len_wr  = cfg_we && ((cfg_idx == REG_TAP1_LENGTH) || (cfg_idx == REG_TAP2_LENGTH));

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap1_length_reg <= LEN_W'(1);
            tap2_length_reg <= LEN_W'(1);
            tap_gains_reg   <= 32'h0000_0000;
            tap_pans_reg    <= 32'h4000_4000;
            feedbacks_reg   <= 32'h0000_0000;
            damping_reg     <= COEF_W'(32768);
            volume_reg      <= COEF_W'(16384);
            crossmix_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_TAP1_LENGTH: tap1_length_reg <= pwdata[LEN_W-1:0];
                REG_TAP2_LENGTH: tap2_length_reg <= pwdata[LEN_W-1:0];
                REG_TAP_GAINS:   tap_gains_reg   <= pwdata;
                REG_TAP_PANS:    tap_pans_reg    <= pwdata;
                REG_FEEDBACKS:   feedbacks_reg   <= pwdata;
                REG_DAMPING:     damping_reg     <= pwdata[COEF_W-1:0];
                REG_VOLUME:      volume_reg      <= pwdata[COEF_W-1:0];
                REG_CROSSMIX:    crossmix_reg    <= pwdata[COEF_W-1:0];
                default:         ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            REG_TAP1_LENGTH: prdata = 32'(tap1_length_reg);
            REG_TAP2_LENGTH: prdata = 32'(tap2_length_reg);
            REG_TAP_GAINS:   prdata = tap_gains_reg;
            REG_TAP_PANS:    prdata = tap_pans_reg;
            REG_FEEDBACKS:   prdata = feedbacks_reg;
            REG_DAMPING:     prdata = 32'(damping_reg);
            REG_VOLUME:      prdata = 32'(volume_reg);
            REG_CROSSMIX:    prdata = 32'(crossmix_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------

    assign run    = (state_reg == ST_RUN);
    assign finish = run && (step_reg == STEP_DONE) && (!out_valid_reg || sample_out.ready);

    // a new transaction may start on the cycle the previous one retires
    assign sample_in.ready = (state_reg == ST_IDLE) || finish;
    assign in_accept       = sample_in.valid && sample_in.ready;

    // next state and step
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_RUN;
                    step_next  = STEP_XG_L;
                end
            end
            ST_RUN:
            begin
                if (in_accept)
                begin
                    step_next = STEP_XG_L;
                end
                else if (finish)
                begin
                    state_next = ST_IDLE;
                    step_next  = STEP_XG_L;
                end
                else if (step_reg != STEP_DONE)
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = STEP_XG_L;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_XG_L;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // input capture and sum of both taps ahead of the volume step
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_left_reg  <= sample_in.left_in;
            x_right_reg <= sample_in.right_in;
        end
        if (run && (step_reg == STEP_DMP_L1))
        begin
            sum_left_reg  <= tl_reg[0] + tl_reg[1];
            sum_right_reg <= tr_reg[0] + tr_reg[1];
        end
    end

    // ------------------------------------------------------------------
    // tap lanes: one store memory and one multiply-accumulate each
    // ------------------------------------------------------------------

    for (genvar t = 0; t < NUM_TAPS; t++)
    begin : g_tap
        logic [2*SAMPLE_W-1:0] store_mem [MAX_DELAY];
        logic [2*SAMPLE_W-1:0] rdata_reg;
        op_a_t                 pl_reg;
        op_a_t                 pr_reg;
        op_a_t                 ml_reg;
        op_a_t                 mr_reg;
        op_a_t                 a_op;
        op_a_t                 dl;
        op_a_t                 dr;
        op_a_t                 rd;
        op_b_t                 b_op;
        op_b_t                 g_coef;
        op_b_t                 pan_coef;
        op_b_t                 npan_coef;
        op_b_t                 fb_coef;
        op_b_t                 cm_coef;
        op_b_t                 ncm_coef;
        op_b_t                 dmp_coef;
        op_b_t                 ndmp_coef;
        acc_t                  bias;
        acc_t                  prod;
        acc_t                  acc_next;
        logic                  mac_en;
        logic                  mac_first;
        logic                  mem_rd;

        assign last_idx[t] = last_index((t == 0) ? tap1_length_reg : tap2_length_reg);

        // per-tap coefficients
        assign g_coef    = coef_q15(tap_gains_reg[COEF_W*t +: COEF_W]);
        assign pan_coef  = coef_q15(tap_pans_reg[COEF_W*t +: COEF_W]);
        assign npan_coef = compl_q15(tap_pans_reg[COEF_W*t +: COEF_W]);
        assign fb_coef   = coef_q15(feedbacks_reg[COEF_W*t +: COEF_W]);
        assign cm_coef   = coef_q15(crossmix_reg);
        assign ncm_coef  = compl_q15(crossmix_reg);
        assign dmp_coef  = coef_q15(damping_reg);
        assign ndmp_coef = compl_q15(damping_reg);

        // delayed samples; entries not yet written since the last clear read as zero
        assign dl = wrapped_reg[t] ? op_a_t'(sample_t'(rdata_reg[2*SAMPLE_W-1 -: SAMPLE_W])) : '0;
        assign dr = wrapped_reg[t] ? op_a_t'(sample_t'(rdata_reg[SAMPLE_W-1:0])) : '0;

        // rounded value of the finished accumulation
        assign rd = op_a_t'(acc_reg[t] >>> SHIFT_COEF);

        // operand selection per step
        always_comb
        begin
            mac_en    = run;
            mac_first = 1'b1;
            bias      = RND_COEF;
            a_op      = '0;
            b_op      = '0;
            case (step_reg)
                STEP_XG_L:
                begin
                    a_op = op_a_t'(x_left_reg);
                    b_op = g_coef;
                end
                STEP_PAN_L:
                begin
                    a_op = rd;
                    b_op = pan_coef;
                end
                STEP_XG_R:
                begin
                    a_op = op_a_t'(x_right_reg);
                    b_op = g_coef;
                end
                STEP_PAN_R:
                begin
                    a_op = rd;
                    b_op = npan_coef;
                end
                STEP_MIX_L0:
                begin
                    a_op = dl;
                    b_op = ncm_coef;
                end
                STEP_MIX_L1:
                begin
                    mac_first = 1'b0;
                    a_op      = dr;
                    b_op      = cm_coef;
                end
                STEP_MIX_R0:
                begin
                    a_op = dr;
                    b_op = ncm_coef;
                end
                STEP_MIX_R1:
                begin
                    mac_first = 1'b0;
                    a_op      = dl;
                    b_op      = cm_coef;
                end
                STEP_FB_L:
                begin
                    a_op = ml_reg;
                    b_op = fb_coef;
                end
                STEP_FB_R:
                begin
                    a_op = mr_reg;
                    b_op = fb_coef;
                end
                STEP_DMP_L0:
                begin
                    a_op = tl_reg[t];
                    b_op = dmp_coef;
                end
                STEP_DMP_L1:
                begin
                    mac_first = 1'b0;
                    a_op      = op_a_t'(hl_reg[t]);
                    b_op      = ndmp_coef;
                end
                STEP_DMP_R0:
                begin
                    a_op = tr_reg[t];
                    b_op = dmp_coef;
                end
                STEP_DMP_R1:
                begin
                    mac_first = 1'b0;
                    a_op      = op_a_t'(hr_reg[t]);
                    b_op      = ndmp_coef;
                end
                STEP_VOL:
                begin
                    // lane 0 forms the left output, lane 1 the right
                    bias = RND_VOL;
                    a_op = (t == 0) ? sum_left_reg : sum_right_reg;
                    b_op = coef_q15(volume_reg);
                end
                default:
                begin
                    mac_en = 1'b0;
                end
            endcase
        end

        // multiply-accumulate
        assign prod     = a_op * b_op;
        assign acc_next = (mac_first ? bias : acc_reg[t]) + prod;

        always_ff @(posedge clk)
        begin
            if (mac_en)
            begin
                acc_reg[t] <= acc_next;
            end
        end

        // intermediate terms of the tap signal
        always_ff @(posedge clk)
        begin
            if (run)
            begin
                case (step_reg)
                    STEP_XG_R:   pl_reg    <= rd;
                    STEP_MIX_L0: pr_reg    <= rd;
                    STEP_MIX_R0: ml_reg    <= rd;
                    STEP_FB_L:   mr_reg    <= rd;
                    STEP_FB_R:   tl_reg[t] <= pl_reg - rd;
                    STEP_DMP_L0: tr_reg[t] <= pr_reg - rd;
                    default:     ;
                endcase
            end
        end

        // damping history
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hl_reg[t] <= '0;
                hr_reg[t] <= '0;
            end
            else if (len_wr)
            begin
                hl_reg[t] <= '0;
                hr_reg[t] <= '0;
            end
            else if (run && (step_reg == STEP_DMP_R0))
            begin
                hl_reg[t] <= sat_sample(acc_reg[t] >>> SHIFT_COEF);
            end
            else if (run && (step_reg == STEP_VOL))
            begin
                hr_reg[t] <= sat_sample(acc_reg[t] >>> SHIFT_COEF);
            end
        end

        // position and wrap flag
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pos_reg[t]     <= '0;
                wrapped_reg[t] <= 1'b0;
            end
            else if (len_wr)
            begin
                pos_reg[t]     <= '0;
                wrapped_reg[t] <= 1'b0;
            end
            else if (finish)
            begin
                if (pos_reg[t] == last_idx[t])
                begin
                    pos_reg[t]     <= '0;
                    wrapped_reg[t] <= 1'b1;
                end
                else
                begin
                    pos_reg[t] <= pos_reg[t] + ADDR_W'(1);
                end
            end
        end

        // store memory: read at the first step, damped pair written back on retire;
        // the next read always comes after the write
        assign mem_rd = run && (step_reg == STEP_XG_L);

        always_ff @(posedge clk)
        begin
            if (finish)
            begin
                store_mem[pos_reg[t]] <= {hl_reg[t], hr_reg[t]};
            end
            if (mem_rd)
            begin
                rdata_reg <= store_mem[pos_reg[t]];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (sample_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_left_reg  <= sat_sample(acc_reg[0] >>> SHIFT_VOL);
            out_right_reg <= sat_sample(acc_reg[1] >>> SHIFT_VOL);
        end
    end

    assign sample_out.valid     = out_valid_reg;
    assign sample_out.left_out  = out_left_reg;
    assign sample_out.right_out = out_right_reg;

`ifndef SYNTHESIS
    // a result appears only when a transaction retires
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(finish))
        else $error("output valid without a retiring transaction");

    // a length write restarts both taps
    a_len_clears: assert property (@(posedge clk) disable iff (!rst_n)
        len_wr |=> (pos_reg[0] == '0) && (pos_reg[1] == '0) && !wrapped_reg[0] && !wrapped_reg[1])
        else $error("length write did not clear tap positions");

    // positions stay inside the configured lengths
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg[0] <= last_idx[0]) && (pos_reg[1] <= last_idx[1]))
        else $error("tap position beyond its length");
`endif

endmodule

`default_nettype wire

### bench/stereo_dual_tap_feedback_delay_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_dual_tap_feedback_delay_tb
// Self-checking bench for the stereo dual-tap feedback delay. A directed table
// covers the reset state, sample extremes, over-unity coefficients and length
// corner cases. Randomised phases retune coefficients, often lengths too, and stream
// sample pairs under random source gaps and sink stalls. An in-bench echo
// predictor tracks both taps' stores, positions and damping history, and each
// output pair is compared against it in order. Register writes are read back.
// ----------------------------------------------------------------------------

module stereo_dual_tap_feedback_delay_tb;
    import sdtfd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 160;
    localparam int MAX_REPORTS  = 40;

    // register map, one word per register
    typedef enum int {
        REG_TAP1_LEN  = 0,
        REG_TAP2_LEN  = 1,
        REG_TAP_GAINS = 2,
        REG_TAP_PANS  = 3,
        REG_FEEDBACKS = 4,
        REG_DAMPING   = 5,
        REG_VOLUME    = 6,
        REG_CROSSMIX  = 7
    } reg_idx_e;

    typedef enum bit {ROW_PAIR, ROW_WRITE} row_kind_e;

    typedef struct {
        row_kind_e   kind;
        reg_idx_e    idx;
        logic [31:0] value;
        sample_t     l;
        sample_t     r;
        bit          typed;
        sample_t     el;
        sample_t     er;
    } stim_row_t;

    typedef struct {
        sample_t l;
        sample_t r;
    } pair_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sdtfd_in_if  smp_in ();
    sdtfd_out_if smp_out ();

    // predictor copy of the settings and the echo state
    logic [LEN_W-1:0]  cfg_len [NUM_TAPS];
    logic [31:0]       cfg_gains;
    logic [31:0]       cfg_pans;
    logic [31:0]       cfg_fbs;
    logic [COEF_W-1:0] cfg_damp;
    logic [COEF_W-1:0] cfg_vol;
    logic [COEF_W-1:0] cfg_xmix;
    sample_t           echo_store [NUM_TAPS][2][MAX_DELAY];
    int unsigned       tap_pos [NUM_TAPS];
    sample_t           damp_hist [NUM_TAPS][2];

    pair_t pending_pairs[$];
    int    err_count    = 0;
    int    result_count = 0;
    int    cycle_count  = 0;
    int    stall_left   = 0;
    bit    idle_en      = 1'b1;

    // directed stimulus: typed results only where they follow at a glance
    stim_row_t directed_rows [] = '{
        // reset state: zero gains give silence
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h7FFFFF, 24'h800000, 1'b1, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h800000, 24'h7FFFFF, 1'b1, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h000000, 24'h000000, 1'b1, 24'h0, 24'h0},
        // unity gains, half pans, unit output: input passes through, up to rounding
        '{ROW_WRITE, REG_TAP_GAINS, 32'h80008000, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h7FFFFF, 24'h800000, 1'b1,
          24'h7FFFFF, 24'h800000},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h800000, 24'h7FFFFF, 1'b1,
          24'h800000, 24'h7FFFFF},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h000001, 24'hFFFFFF, 1'b1,
          24'h000002, 24'h000000},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h000000, 24'h000000, 1'b1, 24'h0, 24'h0},
        // impulse through short feedback loops with crossmix
        '{ROW_WRITE, REG_FEEDBACKS, 32'h40004000, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_WRITE, REG_CROSSMIX,  32'h00004000, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_WRITE, REG_TAP1_LEN,  32'h00000003, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_WRITE, REG_TAP2_LEN,  32'h00000005, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h400000, 24'hE00000, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
        // damping on, pan above one, full volume with junk in the upper bits
        '{ROW_WRITE, REG_DAMPING,   32'h00002000, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_WRITE, REG_TAP_PANS,  32'hFFFF0000, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_WRITE, REG_VOLUME,    32'hFFFFFFFF, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h800000, 24'h800000, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
        // crossmix above one and heavy feedback: saturation in the loop
        '{ROW_WRITE, REG_CROSSMIX,  32'h0000FFFF, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_WRITE, REG_FEEDBACKS, 32'hFFFF8000, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h123456, 24'h9ABCDF, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
        // zero length acts as one, oversized length clamps
        '{ROW_WRITE, REG_TAP1_LEN,  32'h00000000, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_WRITE, REG_TAP2_LEN,  32'hFFFFFFFF, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h7FFFFF, 24'h000001, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0},
        // longest lengths, damping above one
        '{ROW_WRITE, REG_TAP1_LEN,  32'h00010000, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_WRITE, REG_TAP2_LEN,  32'h00010001, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_WRITE, REG_DAMPING,   32'h0000FFFF, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'hFFFFFF, 24'h000001, 1'b0, 24'h0, 24'h0},
        '{ROW_PAIR,  REG_TAP1_LEN,  32'h0, 24'h555555, 24'hAAAAAA, 1'b0, 24'h0, 24'h0}
    };

    stereo_dual_tap_feedback_delay dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (smp_in),
        .sample_out (smp_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        if (err_count < MAX_REPORTS)
        begin
            $display("mismatch at %0t: %s got %0d expected %0d (result %0d)",
                     $time, what, got, want, result_count);
        end
        err_count++;
    endtask

    // floor((p + half) / 2^sh)
    function automatic longint round_shift(longint p, int sh);
        return (p + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp_sample(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (SAMPLE_W - 1)) - 1;
        lo = -(longint'(1) << (SAMPLE_W - 1));
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    // stores, damping history and positions back to zero
    function automatic void clear_echo_state();
        foreach (echo_store[t, c, i])
        begin
            echo_store[t][c][i] = '0;
        end
        foreach (damp_hist[t, c])
        begin
            damp_hist[t][c] = '0;
        end
        foreach (tap_pos[t])
        begin
            tap_pos[t] = 0;
        end
    endfunction

    function automatic void apply_setting(reg_idx_e idx, logic [31:0] v);
        case (idx)
            REG_TAP1_LEN:
            begin
                cfg_len[0] = v[LEN_W-1:0];
                clear_echo_state();
            end
            REG_TAP2_LEN:
            begin
                cfg_len[1] = v[LEN_W-1:0];
                clear_echo_state();
            end
            REG_TAP_GAINS: cfg_gains = v;
            REG_TAP_PANS:  cfg_pans  = v;
            REG_FEEDBACKS: cfg_fbs   = v;
            REG_DAMPING:   cfg_damp  = v[COEF_W-1:0];
            REG_VOLUME:    cfg_vol   = v[COEF_W-1:0];
            REG_CROSSMIX:  cfg_xmix  = v[COEF_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] setting_value(reg_idx_e idx);
        case (idx)
            REG_TAP1_LEN:  return 32'(cfg_len[0]);
            REG_TAP2_LEN:  return 32'(cfg_len[1]);
            REG_TAP_GAINS: return cfg_gains;
            REG_TAP_PANS:  return cfg_pans;
            REG_FEEDBACKS: return cfg_fbs;
            REG_DAMPING:   return 32'(cfg_damp);
            REG_VOLUME:    return 32'(cfg_vol);
            REG_CROSSMIX:  return 32'(cfg_xmix);
            default:       return 32'h0;
        endcase
    endfunction

    // one stereo pair through both taps; updates the echo state
    function automatic void echo_predict(input sample_t xl, input sample_t xr,
                                         output sample_t yl, output sample_t yr);
        longint      x [2];
        longint      d [2];
        longint      m [2];
        longint      sig [NUM_TAPS][2];
        longint      g;
        longint      pan;
        longint      fb;
        longint      cm;
        longint      ncm;
        longint      dmp;
        longint      ndmp;
        longint      vol;
        longint      y;
        int unsigned len;
        int unsigned p;
        x[0] = xl;
        x[1] = xr;
        cm   = longint'(cfg_xmix);
        ncm  = ONE_Q15 - cm;
        dmp  = longint'(cfg_damp);
        ndmp = ONE_Q15 - dmp;
        for (int tap = 0; tap < NUM_TAPS; tap++)
        begin
            g   = longint'(cfg_gains[tap*COEF_W +: COEF_W]);
            pan = longint'(cfg_pans[tap*COEF_W +: COEF_W]);
            fb  = longint'(cfg_fbs[tap*COEF_W +: COEF_W]);
            len = cfg_len[tap];
            if (len == 0)
            begin
                len = 1;
            end
            if (len > MAX_DELAY)
            begin
                len = MAX_DELAY;
            end
            p = tap_pos[tap];
            if (p >= len)
            begin
                p = 0;
            end
            // delayed values, cross-mixed between channels
            d[0] = echo_store[tap][0][p];
            d[1] = echo_store[tap][1][p];
            m[0] = round_shift(d[0] * ncm + d[1] * cm, SHIFT_COEF);
            m[1] = round_shift(d[1] * ncm + d[0] * cm, SHIFT_COEF);
            // panned, gained input less the fed-back value
            sig[tap][0] = round_shift(round_shift(x[0] * g, SHIFT_COEF) * pan, SHIFT_COEF)
                          - round_shift(m[0] * fb, SHIFT_COEF);
            sig[tap][1] = round_shift(round_shift(x[1] * g, SHIFT_COEF) * (ONE_Q15 - pan),
                                      SHIFT_COEF)
                          - round_shift(m[1] * fb, SHIFT_COEF);
            // one-pole low-pass, written back to store and history
            for (int ch = 0; ch < 2; ch++)
            begin
                y = clamp_sample(round_shift(sig[tap][ch] * dmp
                                             + longint'(damp_hist[tap][ch]) * ndmp,
                                             SHIFT_COEF));
                echo_store[tap][ch][p] = sample_t'(y);
                damp_hist[tap][ch]     = sample_t'(y);
            end
            p++;
            if (p >= len)
            begin
                p = 0;
            end
            tap_pos[tap] = p;
        end
        vol = longint'(cfg_vol);
        yl  = sample_t'(clamp_sample(round_shift((sig[0][0] + sig[1][0]) * vol, SHIFT_VOL)));
        yr  = sample_t'(clamp_sample(round_shift((sig[0][1] + sig[1][1]) * vol, SHIFT_VOL)));
    endfunction

    // apb transfer: setup then access, data taken at the access edge
    task automatic apb_access(bit wr, logic [4:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // write a register, mirror it, read it back
    task automatic write_setting(reg_idx_e idx, logic [31:0] v);
        logic [31:0] rd;
        logic [4:0]  addr;
        addr = 5'(int'(idx) * 4);
        apb_access(1'b1, addr, v, rd);
        apply_setting(idx, v);
        apb_access(1'b0, addr, 32'h0, rd);
        if (rd !== setting_value(idx))
        begin
            report_mismatch({"readback of ", idx.name()}, rd, setting_value(idx));
        end
    endtask

    // drop valid and let every pending result drain out
    task automatic wait_idle();
        @(negedge clk);
        smp_in.valid = 1'b0;
        while (pending_pairs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // offer one sample pair and queue its expected output on acceptance
    task automatic push_pair(sample_t l, sample_t r, bit typed, sample_t el, sample_t er);
        int      gap;
        pair_t   want;
        sample_t pl;
        sample_t pr;
        @(negedge clk);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            gap          = $urandom_range(1, 3);
            smp_in.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        smp_in.valid    = 1'b1;
        smp_in.left_in  = l;
        smp_in.right_in = r;
        do
        begin
            @(posedge clk);
        end
        while (smp_in.ready !== 1'b1);
        echo_predict(l, r, pl, pr);
        want.l = typed ? el : pl;
        want.r = typed ? er : pr;
        pending_pairs.push_back(want);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h7FFF;
            4, 5:    return COEF_W'($urandom_range(0, ONE_Q15));
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // mostly short loops so echoes come round many times
    function automatic logic [LEN_W-1:0] pick_length(int tap);
        case ($urandom_range(0, 7))
            0:       return 1;
            1:       return 2;
            2:       return LEN_W'(MAX_DELAY);
            3:       return '0;
            4:       return '1;
            5:       return cfg_len[tap];
            default: return LEN_W'($urandom_range(3, 48));
        endcase
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return sample_t'($urandom_range(0, 1023)) - sample_t'(512);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // new random settings; upper bits carry junk the block must drop
    task automatic retune();
        if ($urandom_range(0, 2) != 0)
        begin
            write_setting(REG_TAP1_LEN, {15'($urandom), pick_length(0)});
            write_setting(REG_TAP2_LEN, {15'($urandom), pick_length(1)});
        end
        write_setting(REG_TAP_GAINS, {pick_coef(), pick_coef()});
        write_setting(REG_TAP_PANS, {pick_coef(), pick_coef()});
        write_setting(REG_FEEDBACKS, {pick_coef(), pick_coef()});
        write_setting(REG_DAMPING, {16'($urandom), pick_coef()});
        write_setting(REG_VOLUME, {16'($urandom), pick_coef()});
        write_setting(REG_CROSSMIX, {16'($urandom), pick_coef()});
    endtask

    // output sink: random stall bursts, with ready raised between them
    initial
    begin
        smp_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                smp_out.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                smp_out.ready = 1'b1;
                if (idle_en && $urandom_range(0, 4) == 0)
                begin
                    stall_left = $urandom_range(1, 3);
                end
            end
        end
    end

    // output check against the oldest pending pair
    always @(posedge clk)
    begin
        pair_t want;
        if (rst_n && smp_out.valid === 1'b1 && smp_out.ready === 1'b1)
        begin
            if (pending_pairs.size() == 0)
            begin
                report_mismatch("output with nothing pending, left", smp_out.left_out, 0);
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (smp_out.left_out !== want.l)
                begin
                    report_mismatch("left_out", smp_out.left_out, want.l);
                end
                if (smp_out.right_out !== want.r)
                begin
                    report_mismatch("right_out", smp_out.right_out, want.r);
                end
            end
            result_count++;
        end
    end

    // main sequence
    initial
    begin
        rst_n           = 1'b0;
        smp_in.valid    = 1'b0;
        smp_in.left_in  = '0;
        smp_in.right_in = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;

        // predictor reset values
        cfg_len[0] = 1;
        cfg_len[1] = 1;
        cfg_gains  = 32'h0;
        cfg_pans   = 32'h40004000;
        cfg_fbs    = 32'h0;
        cfg_damp   = 16'h8000;
        cfg_vol    = 16'h4000;
        cfg_xmix   = 16'h0;
        clear_echo_state();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_setting(directed_rows[i].idx, directed_rows[i].value);
            end
            else
            begin
                push_pair(directed_rows[i].l, directed_rows[i].r, directed_rows[i].typed,
                          directed_rows[i].el, directed_rows[i].er);
            end
        end

        // random phases, the last one without idling
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            idle_en = (ph != NUM_PHASES - 1);
            retune();
            repeat (PHASE_ITEMS) push_pair(pick_sample(), pick_sample(), 1'b0, '0, '0);
        end

        wait_idle();
        if (err_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
